/* rtl/sprite_quad_vertex_setup_assert.svh */
// Assertion helpers for the sprite quad setup block.
// Both sample on clk and are disabled while rst is high.
`ifndef SPRITE_QUAD_VERTEX_SETUP_ASSERT_SVH
`define SPRITE_QUAD_VERTEX_SETUP_ASSERT_SVH

// same-cycle implication
`define SQVS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sqvs: same-cycle check failed");

// next-cycle implication
`define SQVS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sqvs: next-cycle check failed");

`endif

/* rtl/sqvs_pkg.sv */
`default_nettype none
package sqvs_pkg;

  localparam int POS_FRAC_BITS = 8;
  localparam int UV_FRAC_BITS  = 16;
  localparam int TRIG_BITS     = 16;
  localparam int POS_SHIFT     = TRIG_BITS - 1 - POS_FRAC_BITS;

  // sin(pi/2 * x) Taylor coefficients, Q30
  localparam logic [31:0] K1 = 32'd1686629713;
  localparam logic [31:0] K3 = 32'd693598668;
  localparam logic [31:0] K5 = 32'd85569307;
  localparam logic [31:0] K7 = 32'd5026995;
  localparam logic [31:0] K9 = 32'd172272;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  localparam int DIV_STAGES = 6;
  localparam int DIV_STEPS  = 3;
  localparam int SIDE_DELAY = 7;  // trig and divider latency

  typedef enum logic [2:0] {
    REG_TEX_WIDTH   = 3'd0,
    REG_TEX_HEIGHT  = 3'd1,
    REG_VIEW_WIDTH  = 3'd2,
    REG_VIEW_HEIGHT = 3'd3,
    REG_TEX_ALPHA   = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    CORNER_TL = 2'd0,
    CORNER_TR = 2'd1,
    CORNER_BR = 2'd2,
    CORNER_BL = 2'd3
  } corner_t;

  typedef struct packed {
    logic              emit;
    logic signed [16:0] dw;
    logic signed [16:0] dh;
    logic signed [18:0] cx;
    logic signed [18:0] cy;
    logic [1:0]        flip;
    logic [31:0]       col;
  } side_t;

  typedef struct packed {
    logic              valid;
    side_t             side;
    logic signed [15:0] c;
    logic signed [15:0] s;
    logic [16:0]       u0;
    logic [16:0]       u1;
    logic [16:0]       v0;
    logic [16:0]       v1;
  } quad_t;

  typedef struct packed {
    logic [14:0] rem;
    logic        q;
  } div_step_t;

  // one restoring step: shift in a bit, subtract if it fits
  function automatic div_step_t div_step(logic [14:0] rem, logic b, logic [14:0] den);
    logic [15:0] r2;
    div_step_t   res;
    r2 = {rem, b};
    if (r2 >= {1'b0, den}) begin
      res.rem = 15'(r2 - {1'b0, den});
      res.q   = 1'b1;
    end else begin
      res.rem = r2[14:0];
      res.q   = 1'b0;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

/* rtl/sqvs_trig.sv */
`default_nettype none
// Quarter-wave sine: Horner chain, at most one multiply per stage, 7 stages.
module sqvs_trig import sqvs_pkg::*; (
  input  wire logic              clk,
  input  wire logic [14:0]       r,
  input  wire logic              neg,
  output logic signed [15:0]     m
);

  logic [14:0] rd [1:5];
  logic        nd [1:6];
  logic [30:0] x2 [1:4];
  logic [31:0] t7, t5, t3, t1;
  logic [30:0] s6;

  logic [63:0] p2, p3, p4, p5, p6;
  logic [30:0] s_raw;
  logic [31:0] s_rnd;

  always_comb begin
    p2 = 64'(x2[1]) * 64'(K9);
    p3 = 64'(x2[2]) * 64'(t7);
    p4 = 64'(x2[3]) * 64'(t5);
    p5 = 64'(x2[4]) * 64'(t3);
    p6 = 64'(rd[5]) * 64'(t1);
    s_raw = (p6[63:14] > 50'(Q30_ONE)) ? Q30_ONE : p6[44:14];
    s_rnd = 32'(s6) + 32'h8000;
  end

  always_ff @(posedge clk) begin
    rd[1] <= r;
    nd[1] <= neg;
    x2[1] <= {29'(r) * 29'(r), 2'b00};
    for (int i = 2; i <= 5; i++) rd[i] <= rd[i-1];
    for (int i = 2; i <= 6; i++) nd[i] <= nd[i-1];
    for (int i = 2; i <= 4; i++) x2[i] <= x2[i-1];
    t7 <= K7 - p2[61:30];
    t5 <= K5 - p3[61:30];
    t3 <= K3 - p4[61:30];
    t1 <= K1 - p5[61:30];
    s6 <= s_raw;
    m  <= nd[6] ? -$signed({1'b0, s_rnd[30:16]}) : $signed({1'b0, s_rnd[30:16]});
  end

endmodule
`default_nettype wire

/* rtl/sqvs_div.sv */
`default_nettype none
// Pipelined restoring divider, 3 quotient bits per stage plus output register.
// Requires num >> 17 < den; quotient low 17 bits out.
module sqvs_div import sqvs_pkg::*; (
  input  wire logic        clk,
  input  wire logic [30:0] num,
  input  wire logic [14:0] den,
  output logic [16:0]      q
);

  localparam int WORK_BITS = DIV_STAGES * DIV_STEPS;

  logic [14:0]          rem  [0:DIV_STAGES];
  logic [WORK_BITS-1:0] work [0:DIV_STAGES];
  logic [14:0]          dv   [0:DIV_STAGES];

  assign rem[0]  = {2'b00, num[30:WORK_BITS]};
  assign work[0] = num[WORK_BITS-1:0];
  assign dv[0]   = den;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [14:0]          rem_next;
    logic [WORK_BITS-1:0] work_next;
    div_step_t            st;
    always_comb begin
      rem_next  = rem[g];
      work_next = work[g];
      st        = '0;
      for (int i = 0; i < DIV_STEPS; i++) begin
        st        = div_step(rem_next, work_next[WORK_BITS-1], dv[g]);
        rem_next  = st.rem;
        work_next = {work_next[WORK_BITS-2:0], st.q};
      end
    end
    always_ff @(posedge clk) begin
      rem[g+1]  <= rem_next;
      work[g+1] <= work_next;
      dv[g+1]   <= dv[g];
    end
  end

  always_ff @(posedge clk) begin
    q <= work[DIV_STAGES][16:0];
  end

endmodule
`default_nettype wire

/* rtl/sqvs_quad_out.sv */
`default_nettype none
// Rotation products, then one vertex per cycle from a held quad.
module sqvs_quad_out import sqvs_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire quad_t        quad,
  output logic              vertex_valid,
  output logic [1:0]        corner,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic [16:0]       tex_u,
  output logic [16:0]       tex_v,
  output logic [31:0]       vertex_color,
  output logic              last
);

  // product stage
  logic               p_valid;
  logic signed [32:0] p_cdw, p_sdw, p_cdh, p_sdh;
  logic signed [39:0] p_bx, p_by;
  logic [1:0]         p_flip;
  logic [31:0]        p_col;
  logic [16:0]        p_u0, p_u1, p_v0, p_v1;

  // held quad
  logic signed [32:0] cdw, sdw, cdh, sdh;
  logic signed [39:0] bx, by;
  logic [1:0]         flip;
  logic [31:0]        col;
  logic [16:0]        u0, u1, v0, v1;
  logic [1:0]         k;
  logic               active;

  logic signed [39:0] base_x, base_y;
  logic               right, bottom, xpos, ypos;
  logic signed [39:0] cox, sox, coy, soy, px, py;

  always_comb begin
    base_x = 40'($signed({quad.side.cx, 14'b0})) + 40'sd64;
    base_y = 40'($signed({quad.side.cy, 14'b0})) + 40'sd64;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= quad.valid && quad.side.emit;
    end
    p_cdw  <= quad.c * quad.side.dw;
    p_sdw  <= quad.s * quad.side.dw;
    p_cdh  <= quad.c * quad.side.dh;
    p_sdh  <= quad.s * quad.side.dh;
    p_bx   <= base_x;
    p_by   <= base_y;
    p_flip <= quad.side.flip;
    p_col  <= quad.side.col;
    p_u0   <= quad.u0;
    p_u1   <= quad.u1;
    p_v0   <= quad.v0;
    p_v1   <= quad.v1;
  end

  always_ff @(posedge clk) begin
    if (p_valid) begin
      cdw  <= p_cdw;
      sdw  <= p_sdw;
      cdh  <= p_cdh;
      sdh  <= p_sdh;
      bx   <= p_bx;
      by   <= p_by;
      flip <= p_flip;
      col  <= p_col;
      u0   <= p_u0;
      u1   <= p_u1;
      v0   <= p_v0;
      v1   <= p_v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      k      <= CORNER_TL;
    end else if (p_valid) begin
      active <= 1'b1;
      k      <= CORNER_TL;
    end else if (active) begin
      active <= (k != CORNER_BL);
      k      <= k + 2'd1;
    end
  end

  // corner offset is +/-dw, +/-dh; flips swap the sign
  always_comb begin
    right  = (k == CORNER_TR) || (k == CORNER_BR);
    bottom = k[1];
    xpos   = right ^ flip[0];
    ypos   = bottom ^ flip[1];
    cox    = xpos ? 40'(cdw) : -40'(cdw);
    sox    = xpos ? 40'(sdw) : -40'(sdw);
    coy    = ypos ? 40'(cdh) : -40'(cdh);
    soy    = ypos ? 40'(sdh) : -40'(sdh);
    px     = cox - soy + bx;
    py     = sox + coy + by;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_valid <= 1'b0;
    end else begin
      vertex_valid <= active;
    end
    corner       <= k;
    pos_x        <= px[POS_SHIFT+31:POS_SHIFT];
    pos_y        <= py[POS_SHIFT+31:POS_SHIFT];
    tex_u        <= right ? u1 : u0;
    tex_v        <= bottom ? v1 : v0;
    vertex_color <= col;
    last         <= (k == CORNER_BL);
  end

endmodule
`default_nettype wire

/* rtl/sprite_quad_vertex_setup.sv */
// Sprite quad vertex setup.
// Command channel: an item (one sprite draw request) is taken at a clock edge
// where start is high and busy is low. busy rises after each accept and stays
// high until the throttle counter gap has counted down to zero, so items are
// spaced to match the four vertices each one produces.
// Result channel: vertex_valid marks each vertex for one cycle; the four
// vertices of a quad come on consecutive cycles, TL, TR, BR, BL, with
// last on the BL vertex. The receiver cannot stall the block.
// Path: the input stage registers a request at the accepting edge; it then
// passes the 7-stage sine/cosine and UV divider pipes, the product stage, the
// quad hold and the output register before its first vertex is on the ports.
// Requests that clip away emit nothing.
// Config: cfg_write/cfg_index/cfg_data writes a register at the edge;
// write only while no item is in flight.
// Reset (rst, synchronous): texture and viewport sizes clear to zero, alpha
// modifier to 255, and the pipeline valid bits clear.
`default_nettype none
`include "sprite_quad_vertex_setup_assert.svh"
module sprite_quad_vertex_setup import sqvs_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  output logic              busy,
  input  wire logic         cfg_write,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [14:0]  cfg_data,
  input  wire logic [15:0]  src_x,
  input  wire logic [15:0]  src_y,
  input  wire logic [15:0]  src_w,
  input  wire logic [15:0]  src_h,
  input  wire logic [15:0]  dst_x,
  input  wire logic [15:0]  dst_y,
  input  wire logic [15:0]  dst_w,
  input  wire logic [15:0]  dst_h,
  input  wire logic [31:0]  color_mask,
  input  wire logic [15:0]  rotation,
  input  wire logic [1:0]   flip,
  output logic              vertex_valid,
  output logic [1:0]        corner,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic [16:0]       tex_u,
  output logic [16:0]       tex_v,
  output logic [31:0]       vertex_color,
  output logic              last
);

  // ---- configuration registers ----
  logic [14:0] tex_width, tex_height, view_width, view_height;
  logic [7:0]  tex_alpha_mod;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width     <= '0;
      tex_height    <= '0;
      view_width    <= '0;
      view_height   <= '0;
      tex_alpha_mod <= 8'hFF;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TEX_WIDTH:   tex_width     <= cfg_data;
        REG_TEX_HEIGHT:  tex_height    <= cfg_data;
        REG_VIEW_WIDTH:  view_width    <= cfg_data;
        REG_VIEW_HEIGHT: view_height   <= cfg_data;
        REG_TEX_ALPHA:   tex_alpha_mod <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // ---- accept throttle ----
  logic       accept;
  logic [1:0] gap;

  assign accept = start && !busy;
  assign busy   = (gap != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      gap <= 2'd0;
    end else if (accept) begin
      gap <= 2'd3;
    end else if (gap != 2'd0) begin
      gap <= gap - 2'd1;
    end
  end

  // ---- stage 1: clip, destination select, angle fold ----
  logic               src_full, dst_full, src_ok;
  logic signed [16:0] sx, sy, sxe, sye, tw, th, u0c, v0c, u1c, v1c;
  logic [14:0]        u0_n, u1_n, v0_n, v1_n;
  logic signed [16:0] dw_n, dh_n;
  logic signed [18:0] cx_n, cy_n;
  logic [7:0]         alpha_n;
  logic [15:0]        rot_c;
  logic [14:0]        rs_n, rc_n;

  always_comb begin
    src_full = (src_x == '0) && (src_y == '0) && (src_w == '0) && (src_h == '0);
    dst_full = (dst_x == '0) && (dst_y == '0) && (dst_w == '0) && (dst_h == '0);
    sx  = 17'($signed(src_x));
    sy  = 17'($signed(src_y));
    sxe = sx + 17'($signed(src_w));
    sye = sy + 17'($signed(src_h));
    tw  = $signed({2'b00, tex_width});
    th  = $signed({2'b00, tex_height});
    u0c = src_x[15] ? 17'sd0 : sx;
    v0c = src_y[15] ? 17'sd0 : sy;
    u1c = (sxe < tw) ? sxe : tw;
    v1c = (sye < th) ? sye : th;
    src_ok = !src_w[15] && (src_w != '0) && !src_h[15] && (src_h != '0)
             && (u1c > u0c) && (v1c > v0c);
    u0_n = src_full ? 15'd0 : u0c[14:0];
    v0_n = src_full ? 15'd0 : v0c[14:0];
    u1_n = src_full ? tex_width : u1c[14:0];
    v1_n = src_full ? tex_height : v1c[14:0];

    dw_n = dst_full ? $signed({2'b00, view_width})  : 17'($signed(dst_w));
    dh_n = dst_full ? $signed({2'b00, view_height}) : 17'($signed(dst_h));
    // centre in half pixels
    cx_n = (dst_full ? 19'sd0 : 19'($signed({dst_x, 1'b0}))) + 19'(dw_n);
    cy_n = (dst_full ? 19'sd0 : 19'($signed({dst_y, 1'b0}))) + 19'(dh_n);

    alpha_n = (color_mask[7:0] == 8'hFF) ? tex_alpha_mod : color_mask[7:0];

    // odd quadrants mirror the quarter wave; cosine is sine a quarter turn on
    rot_c = rotation + 16'h4000;
    rs_n  = rotation[14] ? 15'(15'd16384 - {1'b0, rotation[13:0]}) : {1'b0, rotation[13:0]};
    rc_n  = rot_c[14] ? 15'(15'd16384 - {1'b0, rot_c[13:0]}) : {1'b0, rot_c[13:0]};
  end

  logic        s1_valid;
  side_t       s1_side;
  logic [14:0] s1_u0, s1_u1, s1_v0, s1_v1;
  logic [14:0] s1_rs, s1_rc;
  logic        s1_ns, s1_nc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_side.emit <= (tex_width != '0) && (tex_height != '0) && (src_full || src_ok);
    s1_side.dw   <= dw_n;
    s1_side.dh   <= dh_n;
    s1_side.cx   <= cx_n;
    s1_side.cy   <= cy_n;
    s1_side.flip <= flip;
    s1_side.col  <= {color_mask[31:8], alpha_n};
    s1_u0 <= u0_n;
    s1_u1 <= u1_n;
    s1_v0 <= v0_n;
    s1_v1 <= v1_n;
    s1_rs <= rs_n;
    s1_rc <= rc_n;
    s1_ns <= rotation[15];
    s1_nc <= rot_c[15];
  end

  // ---- sine/cosine and UV division pipes ----
  logic signed [15:0] sin_v, cos_v;
  logic [16:0]        uu0, uu1, vv0, vv1;

  sqvs_trig u_sin (.clk(clk), .r(s1_rs), .neg(s1_ns), .m(sin_v));
  sqvs_trig u_cos (.clk(clk), .r(s1_rc), .neg(s1_nc), .m(cos_v));

  sqvs_div u_div_u0 (.clk(clk), .num({s1_u0, 16'b0} + 31'(tex_width[14:1])),
                     .den(tex_width), .q(uu0));
  sqvs_div u_div_u1 (.clk(clk), .num({s1_u1, 16'b0} + 31'(tex_width[14:1])),
                     .den(tex_width), .q(uu1));
  sqvs_div u_div_v0 (.clk(clk), .num({s1_v0, 16'b0} + 31'(tex_height[14:1])),
                     .den(tex_height), .q(vv0));
  sqvs_div u_div_v1 (.clk(clk), .num({s1_v1, 16'b0} + 31'(tex_height[14:1])),
                     .den(tex_height), .q(vv1));

  // side data and valid bits ride alongside
  logic  dly_valid [1:SIDE_DELAY];
  side_t dly_side  [1:SIDE_DELAY];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= SIDE_DELAY; i++) dly_valid[i] <= 1'b0;
    end else begin
      dly_valid[1] <= s1_valid;
      for (int i = 2; i <= SIDE_DELAY; i++) dly_valid[i] <= dly_valid[i-1];
    end
    dly_side[1] <= s1_side;
    for (int i = 2; i <= SIDE_DELAY; i++) dly_side[i] <= dly_side[i-1];
  end

  quad_t quad;

  always_comb begin
    quad.valid = dly_valid[SIDE_DELAY];
    quad.side  = dly_side[SIDE_DELAY];
    quad.c     = cos_v;
    quad.s     = sin_v;
    quad.u0    = uu0;
    quad.u1    = uu1;
    quad.v0    = vv0;
    quad.v1    = vv1;
  end

  // ---- rotation products and vertex sequencing ----
  sqvs_quad_out u_out (
    .clk(clk), .rst(rst), .quad(quad),
    .vertex_valid(vertex_valid), .corner(corner),
    .pos_x(pos_x), .pos_y(pos_y), .tex_u(tex_u), .tex_v(tex_v),
    .vertex_color(vertex_color), .last(last)
  );

  `SQVS_ASSERT_NEXT(a_throttle, accept, busy)
  `SQVS_ASSERT_NEXT(a_quad_run, vertex_valid && !last, vertex_valid)
  `SQVS_ASSERT_NOW(a_last_corner, vertex_valid && last, corner == CORNER_BL)
  `SQVS_ASSERT_NEXT(a_first_after_last, vertex_valid && last && $past(vertex_valid, 4) == 1'b0,
                    !vertex_valid || corner == CORNER_TL)

endmodule
`default_nettype wire
